// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/mts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// types, codes and constants of the markov transition sampler
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int MAX_TRANSITIONS_DEF = 64;
    localparam int WEIGHT_BITS_DEF     = 16;
    localparam int MAX_STATES          = 16;
    localparam int LIM_W               = 9;
    localparam int DICE_W              = 16;
    localparam int MUL_CNT_W           = 4;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_STEP  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_RANGE = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_STUCK = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  from_state;
        logic [3:0]  to_state;
        logic [15:0] weight;
        logic [15:0] dice;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] current_state;
        logic       changed;
    } rsp_t;

    typedef enum logic [1:0] {
        MOVE_NONE,
        MOVE_LAST,
        MOVE_FOUND
    } move_t;

    typedef struct packed {
        logic       latch;
        logic       clear_tbl;
        logic       rd;
        logic       ev_add;
        logic       ev_sum;
        logic       ev_pick;
        logic       scan_reset;
        logic       mul_step;
        logic       commit_add;
        logic       finish;
        logic [2:0] status;
        move_t      move;
    } cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic scan_last;
        logic dup;
        logic range_bad;
        logic full;
        logic any_cand;
        logic total_zero;
        logic mul_last;
        logic hit;
    } stat_t;

endpackage

// ===== rtl/core/mts_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_datapath
// transition table, scan accumulators, serial multiplier and result register
// ----------------------------------------------------------------------------
module mts_datapath
    import mts_pkg::*;
#(
    parameter int MAX_TRANSITIONS = MAX_TRANSITIONS_DEF,
    parameter int WEIGHT_BITS     = WEIGHT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       request,
    input  logic [4:0] cfg_data,
    input  logic       cfg_we,
    input  cmd_t       cmd,
    output stat_t      stat,
    output rsp_t       result
);

    localparam int AW  = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
    localparam int CW  = $clog2(MAX_TRANSITIONS + 1);
    localparam int TW  = WEIGHT_BITS + CW;
    localparam int TGW = TW + DICE_W;
    localparam int EW  = 8 + WEIGHT_BITS;
    localparam int WW  = (WEIGHT_BITS > 16) ? WEIGHT_BITS : 16;

    logic [EW-1:0]          mem [MAX_TRANSITIONS];
    logic [EW-1:0]          rd_data_reg;

    logic [CW-1:0]          count_reg;
    logic [3:0]             present_reg;
    logic [4:0]             num_states_reg;

    req_t                   req_reg;
    logic [CW-1:0]          idx_reg;
    logic                   dup_reg;
    logic                   any_reg;
    logic [TW-1:0]          total_reg;
    logic [TW-1:0]          cum_reg;
    logic [TGW-1:0]         target_reg;
    logic [DICE_W-1:0]      mcand_reg;
    logic [MUL_CNT_W-1:0]   mul_cnt_reg;
    logic [3:0]             last_dst_reg;
    logic [3:0]             found_dst_reg;
    rsp_t                   result_reg;

    logic [3:0]             rd_src;
    logic [3:0]             rd_dst;
    logic [WEIGHT_BITS-1:0] rd_wgt;
    logic                   src_match;
    logic [TW-1:0]          cum_next;
    logic [TGW-1:0]         cum_shift;
    logic [LIM_W-1:0]       lim;
    logic [WW-1:0]          w_ext;
    logic [WW-1:0]          w_max;
    logic [WW-1:0]          w_sat;
    logic [3:0]             new_state;

    assign rd_src    = rd_data_reg[EW-1 -: 4];
    assign rd_dst    = rd_data_reg[EW-5 -: 4];
    assign rd_wgt    = rd_data_reg[WEIGHT_BITS-1:0];
    assign src_match = (rd_src == present_reg);
    assign cum_next  = cum_reg + TW'(rd_wgt);
    assign cum_shift = {cum_next, {DICE_W{1'b0}}};

    assign lim = ({{(LIM_W-5){1'b0}}, num_states_reg} > LIM_W'(MAX_STATES))
               ? LIM_W'(MAX_STATES) : {{(LIM_W-5){1'b0}}, num_states_reg};

    assign w_ext = WW'(req_reg.weight);
    assign w_max = WW'({WEIGHT_BITS{1'b1}});
    assign w_sat = (w_ext > w_max) ? w_max : w_ext;

    always_comb
    begin
        case (cmd.move)
            MOVE_LAST:  new_state = last_dst_reg;
            MOVE_FOUND: new_state = found_dst_reg;
            default:    new_state = present_reg;
        endcase
    end

    assign stat.cnt_zero   = (count_reg == '0);
    assign stat.scan_last  = ((idx_reg + CW'(1)) == count_reg);
    assign stat.dup        = dup_reg;
    assign stat.range_bad  = ({{(LIM_W-4){1'b0}}, req_reg.from_state} >= lim)
                          || ({{(LIM_W-4){1'b0}}, req_reg.to_state} >= lim);
    assign stat.full       = (count_reg == CW'(MAX_TRANSITIONS));
    assign stat.any_cand   = any_reg;
    assign stat.total_zero = (total_reg == '0);
    assign stat.mul_last   = (mul_cnt_reg == {MUL_CNT_W{1'b1}});
    assign stat.hit        = src_match && (cum_shift >= target_reg);

    assign result = result_reg;

    // table storage
    always_ff @(posedge clk)
    begin
        if (cmd.commit_add)
        begin
            mem[count_reg[AW-1:0]] <= {req_reg.from_state, req_reg.to_state,
                                       w_sat[WEIGHT_BITS-1:0]};
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            present_reg    <= '0;
            num_states_reg <= 5'd1;
        end
        else
        begin
            if (cfg_we)
            begin
                num_states_reg <= cfg_data;
            end
            if (cmd.clear_tbl)
            begin
                count_reg <= '0;
            end
            else if (cmd.commit_add)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.finish)
            begin
                present_reg <= new_state;
            end
        end
    end

    // scan and arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg     <= request;
            idx_reg     <= '0;
            dup_reg     <= 1'b0;
            any_reg     <= 1'b0;
            total_reg   <= '0;
            cum_reg     <= '0;
            target_reg  <= '0;
            mcand_reg   <= request.dice;
            mul_cnt_reg <= '0;
        end
        if (cmd.scan_reset)
        begin
            idx_reg <= '0;
        end
        if (cmd.ev_add)
        begin
            idx_reg <= idx_reg + CW'(1);
            if (rd_src == req_reg.from_state && rd_dst == req_reg.to_state)
            begin
                dup_reg <= 1'b1;
            end
        end
        if (cmd.ev_sum)
        begin
            idx_reg <= idx_reg + CW'(1);
            if (src_match)
            begin
                total_reg    <= total_reg + TW'(rd_wgt);
                any_reg      <= 1'b1;
                last_dst_reg <= rd_dst;
            end
        end
        if (cmd.mul_step)
        begin
            // msb first shift and add
            target_reg  <= {target_reg[TGW-2:0], 1'b0}
                         + (mcand_reg[DICE_W-1] ? TGW'(total_reg) : '0);
            mcand_reg   <= {mcand_reg[DICE_W-2:0], 1'b0};
            mul_cnt_reg <= mul_cnt_reg + MUL_CNT_W'(1);
        end
        if (cmd.ev_pick)
        begin
            idx_reg <= idx_reg + CW'(1);
            if (src_match)
            begin
                cum_reg       <= cum_next;
                found_dst_reg <= rd_dst;
            end
        end
        if (cmd.finish)
        begin
            result_reg.status        <= cmd.status;
            result_reg.current_state <= new_state;
            result_reg.changed       <= (cmd.move != MOVE_NONE);
        end
    end

endmodule

// ===== rtl/core/mts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_ctrl
// request sequencer of the markov transition sampler
// ----------------------------------------------------------------------------
module mts_ctrl
    import mts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] req_type,
    input  stat_t      stat,
    output cmd_t       cmd,
    output logic       busy,
    output logic       done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_EV,
        S_ADD_CHK,
        S_SUM_RD,
        S_SUM_EV,
        S_SUM_CHK,
        S_MUL,
        S_PICK_RD,
        S_PICK_EV,
        S_FINISH
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] code_reg;
    logic [2:0] code_next;
    move_t      move_reg;
    move_t      move_next;
    logic       done_reg;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.move   = MOVE_NONE;
        state_next = state_reg;
        code_next  = code_reg;
        move_next  = move_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    code_next  = ST_OK;
                    move_next  = MOVE_NONE;
                    state_next = S_FINISH;
                    case (req_type)
                        REQ_ADD:   state_next = stat.cnt_zero ? S_ADD_CHK : S_ADD_RD;
                        REQ_STEP:
                        begin
                            if (stat.cnt_zero)
                            begin
                                code_next = ST_STUCK;
                            end
                            else
                            begin
                                state_next = S_SUM_RD;
                            end
                        end
                        REQ_CLEAR: cmd.clear_tbl = 1'b1;
                        default:   state_next = S_FINISH;
                    endcase
                end
            end
            S_ADD_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_ADD_EV;
            end
            S_ADD_EV:
            begin
                cmd.ev_add = 1'b1;
                state_next = stat.scan_last ? S_ADD_CHK : S_ADD_RD;
            end
            S_ADD_CHK:
            begin
                state_next = S_FINISH;
                if (stat.dup)
                begin
                    code_next = ST_DUP;
                end
                else if (stat.range_bad)
                begin
                    code_next = ST_RANGE;
                end
                else if (stat.full)
                begin
                    code_next = ST_FULL;
                end
                else
                begin
                    code_next      = ST_OK;
                    cmd.commit_add = 1'b1;
                end
            end
            S_SUM_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_SUM_EV;
            end
            S_SUM_EV:
            begin
                cmd.ev_sum = 1'b1;
                state_next = stat.scan_last ? S_SUM_CHK : S_SUM_RD;
            end
            S_SUM_CHK:
            begin
                cmd.scan_reset = 1'b1;
                if (!stat.any_cand)
                begin
                    code_next  = ST_STUCK;
                    state_next = S_FINISH;
                end
                else if (stat.total_zero)
                begin
                    move_next  = MOVE_LAST;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                begin
                    state_next = S_PICK_RD;
                end
            end
            S_PICK_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_PICK_EV;
            end
            S_PICK_EV:
            begin
                cmd.ev_pick = 1'b1;
                if (stat.hit)
                begin
                    move_next  = MOVE_FOUND;
                    state_next = S_FINISH;
                end
                else if (stat.scan_last)
                begin
                    move_next  = MOVE_LAST;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_PICK_RD;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                cmd.status = code_reg;
                cmd.move   = move_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
            move_reg  <= MOVE_NONE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
            move_reg  <= move_next;
            done_reg  <= (state_reg == S_FINISH);
        end
    end

endmodule

// ===== rtl/core/markov_transition_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markov_transition_sampler
// weighted transition table with roulette wheel step
// ----------------------------------------------------------------------------
// One request at a time: start is taken while busy is low, and the result
// appears in the cycle after the last internal step, with done high for
// exactly one cycle; the receiver cannot stall it, so it must capture the
// result whenever done is high. The table sits in a single-port memory that
// a scan reads in alternating read and evaluate steps: add makes one pass
// over the table, clear none, and step makes a sum pass over the table,
// a shift-add multiply of dice by the total, then a cumulative pass that
// stops at the chosen entry. A new start may be given in the same cycle
// that done is shown. num_states is written through cfg while busy is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module markov_transition_sampler
    import mts_pkg::*;
#(
    parameter int MAX_TRANSITIONS = MAX_TRANSITIONS_DEF,
    parameter int WEIGHT_BITS     = WEIGHT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  req_t       request,
    output logic       done,
    output rsp_t       result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = !busy;

    mts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (request.req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    mts_datapath #(
        .MAX_TRANSITIONS (MAX_TRANSITIONS),
        .WEIGHT_BITS     (WEIGHT_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cfg_data (cfg_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cmd      (cmd),
        .stat     (stat),
        .result   (result)
    );

    `ASSERT_CLK(a_start_goes_busy, (start && !busy) |=> busy, "accepted request did not go busy")
    `ASSERT_CLK(a_done_after_busy, done |-> $past(busy), "result strobe without a request in flight")
    `ASSERT_CLK(a_changed_is_ok, (done && result.changed) |-> (result.status == ST_OK), "move reported with failing status")
    `ASSERT_NEVER(a_done_twice, done && $past(done), "result strobe held over two cycles")

endmodule

// ===== tb/markov_transition_sampler_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markov_transition_sampler_test
// self-checking bench for the weighted transition table and roulette step
// ----------------------------------------------------------------------------
// Requests are queued by the stimulus process and presented by a clocked
// driver, which updates a local copy of the table and present state on
// every transfer and queues the expected outcome. A clocked monitor
// takes each done strobe and compares status, state and changed flag in
// order. A short directed part covers duplicate and range checks, stuck,
// zero total weight, self loops, an unused request code and the state
// limit at 0, above the maximum and below the present state. Then come
// random build-and-walk sequences mixed with noise under several limits
// and sender gap rates. The limit register is only written while idle.
// ----------------------------------------------------------------------------
module markov_transition_sampler_test
    import mts_pkg::*;
();

    localparam int QUIET_LIMIT = 4000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    req_t       request = '0;
    logic       done;
    rsp_t       result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [4:0] cfg_data = '0;

    req_t        request_q[$];
    rsp_t        outcome_q[$];
    logic [4:0]  state_limit_q[$];

    logic [3:0]  tbl_from [MAX_TRANSITIONS_DEF];
    logic [3:0]  tbl_to [MAX_TRANSITIONS_DEF];
    logic [15:0] tbl_weight [MAX_TRANSITIONS_DEF];
    int unsigned table_used = 0;
    logic [3:0]  walk_state = '0;
    logic [4:0]  num_states_reg = 5'd1;

    int unsigned gen_limit = 1;
    int unsigned sender_idle_pct = 16;
    int unsigned queued_count = 0;
    int unsigned limit_writes = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;

    markov_transition_sampler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic rsp_t apply_request(input req_t r);
        rsp_t        o;
        int unsigned lim;
        int unsigned i;
        int unsigned last_idx;
        int unsigned n_cand;
        bit          found;
        logic [63:0] total;
        logic [63:0] cum;
        logic [63:0] target;
        o = '0;
        o.status = ST_OK;
        lim = (num_states_reg > MAX_STATES) ? MAX_STATES : num_states_reg;
        if (r.req_type == REQ_ADD)
        begin
            found = 1'b0;
            for (i = 0; i < table_used; i++)
                if (tbl_from[i] == r.from_state && tbl_to[i] == r.to_state)
                    found = 1'b1;
            if (found)
                o.status = ST_DUP;
            else if (r.from_state >= lim || r.to_state >= lim)
                o.status = ST_RANGE;
            else if (table_used >= MAX_TRANSITIONS_DEF)
                o.status = ST_FULL;
            else
            begin
                tbl_from[table_used] = r.from_state;
                tbl_to[table_used] = r.to_state;
                tbl_weight[table_used] = r.weight;
                table_used++;
            end
        end
        else if (r.req_type == REQ_STEP)
        begin
            total = '0;
            n_cand = 0;
            last_idx = 0;
            for (i = 0; i < table_used; i++)
                if (tbl_from[i] == walk_state)
                begin
                    total += tbl_weight[i];
                    last_idx = i;
                    n_cand++;
                end
            if (n_cand == 0)
                o.status = ST_STUCK;
            else
            begin
                o.changed = 1'b1;
                found = 1'b0;
                cum = '0;
                target = total * r.dice;
                if (total != 0)
                    for (i = 0; i < table_used; i++)
                        if (!found && tbl_from[i] == walk_state)
                        begin
                            cum += tbl_weight[i];
                            if ((cum << 16) >= target)
                            begin
                                found = 1'b1;
                                walk_state = tbl_to[i];
                            end
                        end
                if (!found)
                    walk_state = tbl_to[last_idx];
            end
        end
        else if (r.req_type == REQ_CLEAR)
            table_used = 0;
        o.current_state = walk_state;
        return o;
    endfunction

    // request driver
    always @(posedge clk)
    begin
        logic next_start;
        req_t next_req;
        next_start = 1'b0;
        next_req = request;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                outcome_q = {outcome_q, apply_request(request)};
                void'(request_q.pop_front());
            end
            if (start && busy)
                next_start = 1'b1;
            else if (request_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                next_start = 1'b1;
                next_req = request_q[0];
            end
        end
        start <= next_start;
        request <= next_req;
    end

    // limit register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                num_states_reg = cfg_data;
                limit_writes++;
                cfg_valid <= 1'b0;
            end
            else if (!cfg_valid && state_limit_q.size() != 0)
            begin
                cfg_valid <= 1'b1;
                cfg_data <= state_limit_q.pop_front();
            end
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // result monitor
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (outcome_q.size() == 0)
                report_mismatch($sformatf("unexpected result %p", result));
            else
            begin
                want = outcome_q.pop_front();
                if (result.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              result.status, want.status));
                if (result.current_state !== want.current_state)
                    report_mismatch($sformatf("current_state got %0d want %0d",
                                              result.current_state, want.current_state));
                if (result.changed !== want.changed)
                    report_mismatch($sformatf("changed got %0d want %0d",
                                              result.changed, want.changed));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic queue_request(input logic [1:0] kind, input logic [3:0] src,
                                 input logic [3:0] dst, input logic [15:0] w,
                                 input logic [15:0] d);
        req_t r;
        r.req_type = kind;
        r.from_state = src;
        r.to_state = dst;
        r.weight = w;
        r.dice = d;
        request_q = {request_q, r};
        queued_count++;
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [3:0] pick_endpoint();
        if (gen_limit == 0)
            return 4'($urandom);
        return 4'($urandom_range(0, gen_limit - 1));
    endfunction

    task automatic wait_quiet();
        while (request_q.size() != 0 || outcome_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_num_states(input logic [4:0] value);
        int unsigned target;
        wait_quiet();
        target = limit_writes + 1;
        state_limit_q = {state_limit_q, value};
        while (limit_writes != target)
            @(posedge clk);
        gen_limit = (value > MAX_STATES) ? MAX_STATES : value;
    endtask

    // build a small chain then walk it
    task automatic queue_walk();
        int n_add;
        int n_step;
        int k;
        n_add = $urandom_range(1, 12);
        n_step = $urandom_range(2, 10);
        if ($urandom_range(0, 1))
            queue_request(REQ_CLEAR, 4'($urandom), 4'($urandom), 16'($urandom),
                          16'($urandom));
        for (k = 0; k < n_add; k++)
            queue_request(REQ_ADD, pick_endpoint(), pick_endpoint(), pick_value(),
                          16'($urandom));
        for (k = 0; k < n_step; k++)
            queue_request(REQ_STEP, 4'($urandom), 4'($urandom), 16'($urandom),
                          pick_value());
    endtask

    task automatic queue_noise();
        int n;
        int k;
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++)
            queue_request(2'($urandom_range(0, 3)), 4'($urandom), 4'($urandom),
                          pick_value(), pick_value());
    endtask

    // fill every slot with distinct pairs, overflow twice, then walk
    task automatic queue_fill();
        int k;
        queue_request(REQ_CLEAR, 4'd0, 4'd0, 16'd0, 16'd0);
        for (k = 0; k < MAX_TRANSITIONS_DEF + 2; k++)
            queue_request(REQ_ADD, 4'(k % 16), 4'(k / 16), pick_value(), 16'($urandom));
        for (k = 0; k < 8; k++)
            queue_request(REQ_STEP, 4'($urandom), 4'($urandom), 16'($urandom),
                          pick_value());
    endtask

    task automatic run_mix(input int unsigned quota);
        int unsigned first;
        first = queued_count;
        while (queued_count - first < quota)
        begin
            if ($urandom_range(0, 9) < 7)
                queue_walk();
            else
                queue_noise();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        sender_idle_pct = 16;

        // limit at reset value of one
        queue_request(REQ_STEP, 4'd0, 4'd0, 16'd0, 16'd1234);
        queue_request(REQ_ADD, 4'd0, 4'd0, 16'hffff, 16'd0);
        queue_request(REQ_ADD, 4'd0, 4'd0, 16'd1, 16'd0);
        queue_request(REQ_ADD, 4'd0, 4'd1, 16'd1, 16'd0);
        queue_request(REQ_ADD, 4'd1, 4'd0, 16'd1, 16'd0);
        queue_request(REQ_STEP, 4'hf, 4'hf, 16'hffff, 16'hffff);
        queue_request(2'd3, 4'hf, 4'hf, 16'hffff, 16'hffff);
        queue_request(REQ_CLEAR, 4'd0, 4'd0, 16'd0, 16'd0);

        write_num_states(5'd0);
        queue_request(REQ_ADD, 4'd0, 4'd0, 16'd5, 16'd0);

        // limit above the maximum, zero total, self loop
        write_num_states(5'd31);
        queue_request(REQ_ADD, 4'd0, 4'd3, 16'd0, 16'd0);
        queue_request(REQ_ADD, 4'd0, 4'd5, 16'd0, 16'd0);
        queue_request(REQ_ADD, 4'hf, 4'hf, 16'd100, 16'd0);
        queue_request(REQ_ADD, 4'd5, 4'hf, 16'hffff, 16'd0);
        queue_request(REQ_ADD, 4'd5, 4'd2, 16'd1, 16'd0);
        queue_request(REQ_ADD, 4'd0, 4'd3, 16'd7, 16'd0);
        queue_request(REQ_STEP, 4'd0, 4'd0, 16'd0, 16'($urandom));
        queue_request(REQ_STEP, 4'd0, 4'd0, 16'd0, 16'd0);

        // present state left above the new limit
        write_num_states(5'd4);
        queue_request(REQ_STEP, 4'd0, 4'd0, 16'd0, 16'h8000);
        queue_request(REQ_ADD, 4'hf, 4'd0, 16'd1, 16'd0);
        queue_request(REQ_ADD, 4'd3, 4'd3, 16'd1, 16'd0);

        write_num_states(5'd16);
        queue_fill();
        run_mix(20);
        write_num_states(5'($urandom_range(2, 6)));
        run_mix(90);

        write_num_states(5'($urandom_range(1, 16)));
        sender_idle_pct = 53;
        run_mix(90);
        write_num_states(5'd31);
        run_mix(90);

        write_num_states(5'd16);
        sender_idle_pct = 0;
        queue_fill();
        run_mix(20);
        write_num_states(5'($urandom_range(2, 15)));
        run_mix(40);

        wait_quiet();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
